@@ hw/rtl/cc2c_pkg.sv @@
package cc2c_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_BUILD = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         row;
    logic [15:0]        col;
    logic signed [31:0] value;
    logic [10:0]        index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [10:0]        merged_count;
    logic [9:0]         row_out;
    logic [15:0]        col_out;
    logic signed [31:0] value_out;
    logic [9:0]         sorted_from;
    logic [9:0]         merged_to;
    logic [10:0]        row_start;
  } out_word_t;

endpackage

@@ hw/rtl/cc2c_ram.sv @@
module cc2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cc2c_cfg.sv @@
module cc2c_cfg #(
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [10:0] eff_rows
);

  logic [10:0] num_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= 11'd1024;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      num_rows_r <= pwdata[10:0];
    end
  end

  // clamp to 1..MAX_ROWS
  always_comb begin
    if (num_rows_r == 11'd0) begin
      eff_rows = 11'd1;
    end else if (32'(num_rows_r) > 32'(MAX_ROWS)) begin
      eff_rows = 11'(MAX_ROWS);
    end else begin
      eff_rows = num_rows_r;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {21'd0, num_rows_r} : 32'd0;
  assign pready = 1'b1;

endmodule

@@ hw/rtl/coo_to_csr_sort_merge_top.sv @@
// Loads, clears and reads: one word per cycle while not busy, result in the cycle after start.
// Build: busy for a merge sort (one read port per buffer, so each element takes a left
// read, a right read and a write), a merge of equal keys and a row pointer sweep
// with wrap-up; result in the first cycle with busy low.
// The receiver cannot stall; every result is shown for one cycle on out_valid.
// Reset clears the state, counts and flags only; memory contents are not cleared.
module coo_to_csr_sort_merge_top
  import cc2c_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int COL_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int WW  = CW + 1;
  localparam int SW  = CW + 2;
  localparam int RPW = $clog2(MAX_ROWS + 1);
  localparam logic [15:0] COL_MASK = 16'((64'd1 << COL_BITS) - 64'd1);

  typedef struct packed {
    logic [9:0]         row;
    logic [15:0]        col;
    logic signed [31:0] value;
    logic [AW-1:0]      pos;
  } rec_t;

  localparam int RW = $bits(rec_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SRT_RL, S_SRT_RR, S_SRT_WR, S_MRG_RD, S_MRG_PROC,
    S_MRG_FLUSH, S_RP_RD, S_RP_CMP, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  state_t        state_r;
  logic [CW-1:0] lc_r, mt_r, st_r, n_r;
  logic          built_r;
  logic [WW-1:0] wd_r;
  logic [CW-1:0] le_r, re_r, li_r, ri_r, o_r;
  logic          sel_r;
  logic [CW-1:0] i_r, w_r, k_r;
  logic [10:0]   r_r, rows_r;
  rec_t          cur_r, left_r;
  logic          ov_r, rd_r, ent_ok_r, map_ok_r, rp_ok_r;
  logic [1:0]    ostat_r;

  logic [10:0]   eff_rows;
  logic          acc;

  logic          b0_we, b1_we, map_we, rp_we;
  logic [AW-1:0] b0_wa, b1_wa, b0_ra, b1_ra, map_wa, map_ra;
  rec_t          b0_wd, b1_wd, q0, q1, src_q, wr_cur;
  logic [19:0]   map_wd, map_q;
  logic [RPW-1:0] rp_wa, rp_ra;
  logic [10:0]   rp_wd, rp_q;

  logic [CW-1:0] seg_lo, seg_le, seg_re, seg_n;
  logic [WW-1:0] seg_wd;
  logic [SW-1:0] sum1, sum2;
  logic          take_left, key_eq, load_ok;

  cc2c_cfg #(.MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .eff_rows
  );

  cc2c_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_buf0 (
    .clk, .we(b0_we), .waddr(b0_wa), .wdata(b0_wd), .raddr(b0_ra), .rdata(q0)
  );
  cc2c_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_buf1 (
    .clk, .we(b1_we), .waddr(b1_wa), .wdata(b1_wd), .raddr(b1_ra), .rdata(q1)
  );
  cc2c_ram #(.WIDTH(20), .DEPTH(MAX_ENTRIES)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_q)
  );
  cc2c_ram #(.WIDTH(11), .DEPTH(MAX_ROWS + 1)) u_rp (
    .clk, .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_q)
  );

  assign busy    = (state_r != S_IDLE);
  assign acc     = start && !busy;
  assign src_q   = sel_r ? q1 : q0;
  assign load_ok = (32'(lc_r) < 32'(MAX_ENTRIES)) && (32'(in_word.row) < 32'(eff_rows));

  assign take_left = (li_r < le_r) &&
                     ((ri_r >= re_r) || !({src_q.row, src_q.col} < {left_r.row, left_r.col}));
  assign key_eq    = (src_q.row == cur_r.row) && (src_q.col == cur_r.col);

  always_comb begin
    wr_cur     = cur_r;
    wr_cur.pos = AW'(w_r);
  end

  // next merge segment: start of build, next pair in the pass, or first pair of next pass
  always_comb begin
    // at build start the entry count is still in lc_r
    seg_n = (state_r == S_IDLE) ? lc_r : n_r;
    if (state_r == S_IDLE) begin
      seg_lo = '0;
      seg_wd = WW'(1);
    end else if (re_r == n_r) begin
      seg_lo = '0;
      seg_wd = wd_r << 1;
    end else begin
      seg_lo = re_r;
      seg_wd = wd_r;
    end
    sum1   = SW'(seg_lo) + SW'(seg_wd);
    sum2   = sum1 + SW'(seg_wd);
    seg_le = (sum1 > SW'(seg_n)) ? seg_n : CW'(sum1);
    seg_re = (sum2 > SW'(seg_n)) ? seg_n : CW'(sum2);
  end

  always_comb begin
    b0_we  = 1'b0;
    b1_we  = 1'b0;
    map_we = 1'b0;
    rp_we  = 1'b0;
    b0_wa  = AW'(lc_r);
    b1_wa  = AW'(o_r);
    b0_wd  = '{row: in_word.row, col: in_word.col & COL_MASK, value: in_word.value,
               pos: AW'(lc_r)};
    b1_wd  = take_left ? left_r : src_q;
    b0_ra  = AW'(in_word.index);
    b1_ra  = AW'(in_word.index);
    map_wa = AW'(i_r);
    map_wd = {10'(src_q.pos), 10'(w_r)};
    map_ra = AW'(in_word.index);
    rp_wa  = RPW'(r_r);
    rp_wd  = 11'(k_r);
    rp_ra  = RPW'(in_word.index);
    case (state_r)
      S_IDLE: begin
        b0_we = acc && (in_word.req_type == REQ_LOAD) && load_ok;
      end
      S_SRT_RL: begin
        b0_ra = AW'(li_r);
        b1_ra = AW'(li_r);
      end
      S_SRT_RR: begin
        b0_ra = AW'(ri_r);
        b1_ra = AW'(ri_r);
      end
      S_SRT_WR: begin
        b0_we = sel_r;
        b1_we = !sel_r;
        b0_wa = AW'(o_r);
        b0_wd = take_left ? left_r : src_q;
      end
      S_MRG_RD: begin
        b0_ra = AW'(i_r);
        b1_ra = AW'(i_r);
      end
      S_MRG_PROC: begin
        map_we = 1'b1;
        b0_wa  = AW'(w_r);
        b0_wd  = wr_cur;
        if (i_r == '0) begin
          map_wd = {10'(src_q.pos), 10'd0};
        end else if (!key_eq) begin
          b0_we  = 1'b1;
          map_wd = {10'(src_q.pos), 10'(w_r + CW'(1))};
        end
      end
      S_MRG_FLUSH: begin
        b0_we = 1'b1;
        b0_wa = AW'(w_r);
        b0_wd = wr_cur;
      end
      S_RP_RD: begin
        b0_ra = AW'(k_r);
      end
      S_RP_CMP: begin
        b0_ra = AW'(k_r);
        rp_we = !((k_r < mt_r) && ({1'b0, q0.row} < r_r));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lc_r    <= '0;
      mt_r    <= '0;
      st_r    <= '0;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      rd_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (in_word.req_type)
              REQ_CLEAR: begin
                lc_r    <= '0;
                mt_r    <= '0;
                st_r    <= '0;
                built_r <= 1'b0;
                ov_r    <= 1'b1;
                ostat_r <= ST_OK;
              end
              REQ_LOAD: begin
                ov_r <= 1'b1;
                if (32'(lc_r) >= 32'(MAX_ENTRIES)) begin
                  ostat_r <= ST_FULL;
                end else if (!load_ok) begin
                  ostat_r <= ST_ROW;
                end else begin
                  ostat_r <= ST_OK;
                  lc_r    <= lc_r + CW'(1);
                  built_r <= 1'b0;
                end
              end
              REQ_BUILD: begin
                n_r    <= lc_r;
                rows_r <= eff_rows;
                sel_r  <= 1'b0;
                i_r    <= '0;
                k_r    <= '0;
                r_r    <= '0;
                wd_r   <= seg_wd;
                li_r   <= seg_lo;
                le_r   <= seg_le;
                ri_r   <= seg_le;
                re_r   <= seg_re;
                o_r    <= '0;
                if (lc_r == '0) begin
                  mt_r    <= '0;
                  state_r <= S_RP_RD;
                end else if (lc_r == CW'(1)) begin
                  state_r <= S_MRG_RD;
                end else begin
                  state_r <= S_SRT_RL;
                end
              end
              default: begin
                ov_r     <= 1'b1;
                ent_ok_r <= (32'(in_word.index) < 32'(mt_r)) &&
                            (32'(in_word.index) < 32'(MAX_ENTRIES));
                map_ok_r <= 32'(in_word.index) < 32'(st_r);
                rp_ok_r  <= in_word.index <= eff_rows;
                if (!built_r || ((in_word.index > eff_rows) &&
                                 (32'(in_word.index) >= 32'(st_r)))) begin
                  ostat_r <= ST_BAD;
                end else begin
                  ostat_r <= ST_OK;
                  rd_r    <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SRT_RL: state_r <= S_SRT_RR;
        S_SRT_RR: begin
          left_r  <= src_q;
          state_r <= S_SRT_WR;
        end
        S_SRT_WR: begin
          o_r <= o_r + CW'(1);
          if (take_left) begin
            li_r <= li_r + CW'(1);
          end else begin
            ri_r <= ri_r + CW'(1);
          end
          state_r <= S_SRT_RL;
          if (o_r + CW'(1) == re_r) begin
            wd_r <= seg_wd;
            li_r <= seg_lo;
            le_r <= seg_le;
            ri_r <= seg_le;
            re_r <= seg_re;
            if (re_r == n_r) begin
              // pass finished: result now sits in the other buffer
              sel_r <= !sel_r;
              o_r   <= '0;
              if (SW'(seg_wd) >= SW'(n_r)) begin
                state_r <= S_MRG_RD;
              end
            end
          end
        end
        S_MRG_RD: state_r <= S_MRG_PROC;
        S_MRG_PROC: begin
          if (i_r == '0) begin
            cur_r <= src_q;
            w_r   <= '0;
          end else if (key_eq) begin
            cur_r.value <= sat_add(cur_r.value, src_q.value);
          end else begin
            cur_r <= src_q;
            w_r   <= w_r + CW'(1);
          end
          i_r     <= i_r + CW'(1);
          state_r <= (i_r + CW'(1) == n_r) ? S_MRG_FLUSH : S_MRG_RD;
        end
        S_MRG_FLUSH: begin
          mt_r    <= w_r + CW'(1);
          state_r <= S_RP_RD;
        end
        S_RP_RD: state_r <= S_RP_CMP;
        S_RP_CMP: begin
          if ((k_r < mt_r) && ({1'b0, q0.row} < r_r)) begin
            k_r     <= k_r + CW'(1);
            state_r <= S_RP_RD;
          end else if (r_r == rows_r) begin
            state_r <= S_DONE;
          end else begin
            r_r <= r_r + 11'd1;
          end
        end
        S_DONE: begin
          lc_r    <= mt_r;
          st_r    <= n_r;
          built_r <= 1'b1;
          ov_r    <= 1'b1;
          ostat_r <= ST_OK;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    out_word              = '0;
    out_word.status       = ostat_r;
    out_word.merged_count = 11'(mt_r);
    if (rd_r) begin
      if (ent_ok_r) begin
        out_word.row_out   = q0.row;
        out_word.col_out   = q0.col;
        out_word.value_out = q0.value;
      end
      if (map_ok_r) begin
        out_word.sorted_from = map_q[19:10];
        out_word.merged_to   = map_q[9:0];
      end
      if (rp_ok_r) begin
        out_word.row_start = rp_q;
      end
    end
  end

  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_word.req_type == REQ_BUILD) |=> busy)
    else $error("build did not start");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid && (state_r == S_IDLE))
    else $error("build finished without result");

  a_merged_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    mt_r <= lc_r)
    else $error("merged count above loaded count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lc_r) <= 32'(MAX_ENTRIES))
    else $error("loaded count overflow");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy |-> $past(state_r) == S_IDLE)
    else $error("result during build");

endmodule
